FILE: src/oled_framebuffer_refresh_defines.svh
`ifndef OLED_FRAMEBUFFER_REFRESH_DEFINES_SVH
`define OLED_FRAMEBUFFER_REFRESH_DEFINES_SVH

// same-cycle implication, checked on clk with reset masked
`define OFR_ASSERT_NOW(name, pre, post) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("ofr check failed");

// next-cycle implication
`define OFR_ASSERT_NEXT(name, pre, post) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("ofr check failed");

`endif

FILE: src/ofr_pkg.sv
package ofr_pkg;

    localparam int PANEL_WIDTH = 128;
    localparam int PANEL_PAGES = 8;

    localparam int STORE_BYTES = PANEL_WIDTH * PANEL_PAGES;
    localparam int ADDR_W      = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;
    localparam int PAGE_W      = (PANEL_PAGES > 1) ? $clog2(PANEL_PAGES) : 1;
    localparam int PAGE_HDR    = 3;
    localparam int OFF_W       = $clog2(PANEL_WIDTH + PAGE_HDR);

    localparam logic [7:0] CMD_LOW_COL    = 8'h00;
    localparam logic [7:0] CMD_HIGH_COL   = 8'h10;
    localparam logic [7:0] CMD_START_LINE = 8'h40;
    localparam logic [7:0] CMD_PAGE_BASE  = 8'hB0;
    localparam logic [3:0] NIBBLE_MASK    = 4'hF;

    localparam logic [0:0] REG_COLUMN_OFFSET = 1'b0;
    localparam logic [0:0] REG_PAGE_OFFSET   = 1'b1;

    localparam logic [1:0] ACT_DRAW  = 2'd0;
    localparam logic [1:0] ACT_CLEAR = 2'd1;
    localparam logic [1:0] ACT_EMIT  = 2'd2;

    localparam logic [1:0] COL_OFF  = 2'd0;
    localparam logic [1:0] COL_ON   = 2'd1;
    localparam logic [1:0] COL_INV  = 2'd2;

    typedef struct packed {
        logic [7:0]        value;
        logic              is_cmd;
        logic              frame_end;
        logic [ADDR_W-1:0] addr;
    } emit_t;

endpackage

FILE: src/ofr_ram.sv
module ofr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: src/ofr_seq.sv
module ofr_seq (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               advance,
    input  logic [7:0]         column_offset,
    input  logic [2:0]         page_offset,
    output ofr_pkg::emit_t     info
);

    logic                       hdr_reg, hdr_next;
    logic [ofr_pkg::PAGE_W-1:0] page_reg, page_next;
    logic [ofr_pkg::OFF_W-1:0]  off_reg, off_next;
    logic                       last_page;
    logic                       last_off;

    assign last_page = (page_reg == ofr_pkg::PAGE_W'(ofr_pkg::PANEL_PAGES - 1));
    assign last_off  = (off_reg == ofr_pkg::OFF_W'(ofr_pkg::PANEL_WIDTH + ofr_pkg::PAGE_HDR - 1));

    // current stream byte
    always_comb
    begin
        info.value     = 8'h00;
        info.is_cmd    = 1'b1;
        info.frame_end = 1'b0;
        info.addr      = ofr_pkg::ADDR_W'(32'(page_reg) * ofr_pkg::PANEL_WIDTH
                         + 32'(off_reg) - ofr_pkg::PAGE_HDR);
        if (hdr_reg)
        begin
            case (off_reg)
                ofr_pkg::OFF_W'(0): info.value = ofr_pkg::CMD_LOW_COL;
                ofr_pkg::OFF_W'(1): info.value = ofr_pkg::CMD_HIGH_COL;
                default:            info.value = ofr_pkg::CMD_START_LINE;
            endcase
        end
        else
        begin
            case (off_reg)
                ofr_pkg::OFF_W'(0):
                    info.value = 8'(32'(ofr_pkg::CMD_PAGE_BASE) + 32'(page_reg)
                                    + 32'(page_offset));
                ofr_pkg::OFF_W'(1):
                    info.value = {4'h0, column_offset[3:0] & ofr_pkg::NIBBLE_MASK};
                ofr_pkg::OFF_W'(2):
                    info.value = ofr_pkg::CMD_HIGH_COL | {4'h0, column_offset[7:4]};
                default:
                begin
                    info.is_cmd    = 1'b0;
                    info.frame_end = last_off && last_page;
                end
            endcase
        end
    end

    always_comb
    begin
        hdr_next  = hdr_reg;
        page_next = page_reg;
        off_next  = off_reg;
        if (advance)
        begin
            if (hdr_reg)
            begin
                if (off_reg == ofr_pkg::OFF_W'(ofr_pkg::PAGE_HDR - 1))
                begin
                    hdr_next  = 1'b0;
                    off_next  = '0;
                    page_next = '0;
                end
                else
                begin
                    off_next = off_reg + 1'b1;
                end
            end
            else if (last_off)
            begin
                off_next = '0;
                if (last_page)
                begin
                    hdr_next  = 1'b1;
                    page_next = '0;
                end
                else
                begin
                    page_next = page_reg + 1'b1;
                end
            end
            else
            begin
                off_next = off_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hdr_reg  <= 1'b1;
            page_reg <= '0;
            off_reg  <= '0;
        end
        else
        begin
            hdr_reg  <= hdr_next;
            page_reg <= page_next;
            off_reg  <= off_next;
        end
    end

endmodule

FILE: src/oled_framebuffer_refresh.sv
// Page-mode monochrome OLED framebuffer (8 pages x 128 columns, one bit per
// pixel) held in a single-port-write, registered-read RAM. In a draw or an
// emit transaction the accept cycle reads the RAM and the following ST_WORK
// state writes the modified byte back or loads the output register (an emit
// waits in ST_WORK while the output register is still held by the sink). A
// clear transaction sweeps the RAM one byte per cycle, so s_tready stays low
// until every byte has been cleared; the same clearing pass runs after reset.
// Configuration writes are taken at any time and should be made while idle.
// The refresh stream is 3 header commands, then per page 3 commands and 128
// data bytes; m_tlast marks the last data byte of the frame.
module oled_framebuffer_refresh (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // action[1:0], pix_x[8:2], pix_y[14:9], color[16:15]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // out_byte[7:0]
    output logic [0:0]  m_tuser,   // is_command[0]
    output logic        m_tlast,
    input  logic        cfg_we,
    input  logic [0:0]  cfg_index,
    input  logic [7:0]  cfg_data
);

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_WORK  = 3'b010,
        ST_CLEAR = 3'b100
    } state_t;

    state_t                     state_reg, state_next;
    logic [ofr_pkg::ADDR_W-1:0] clr_cnt_reg, clr_cnt_next;
    logic [7:0]                 column_offset_reg;
    logic [2:0]                 page_offset_reg;

    logic [1:0]                 act_reg;
    logic [ofr_pkg::ADDR_W-1:0] addr_reg;
    logic [7:0]                 mask_reg;
    logic [1:0]                 color_reg;
    logic                       hit_reg;
    ofr_pkg::emit_t             info_reg;

    logic                       out_valid_reg, out_valid_next;
    logic [7:0]                 out_byte_reg;
    logic                       out_cmd_reg;
    logic                       out_end_reg;

    logic [1:0]                 in_action;
    logic [6:0]                 in_x;
    logic [5:0]                 in_y;
    logic [1:0]                 in_color;
    logic                       accept;
    logic                       in_hit;
    logic [ofr_pkg::ADDR_W-1:0] draw_addr;
    ofr_pkg::emit_t             seq_info;

    logic                       ram_we;
    logic [ofr_pkg::ADDR_W-1:0] ram_waddr;
    logic [7:0]                 ram_wdata;
    logic [ofr_pkg::ADDR_W-1:0] ram_raddr;
    logic [7:0]                 ram_rdata;
    logic [7:0]                 modified;
    logic                       can_load;
    logic                       load_out;

    assign in_action = s_tdata[1:0];
    assign in_x      = s_tdata[8:2];
    assign in_y      = s_tdata[14:9];
    assign in_color  = s_tdata[16:15];

    assign s_tready  = (state_reg == ST_IDLE);
    assign accept    = s_tvalid && s_tready;

    assign in_hit    = (32'(in_x) < ofr_pkg::PANEL_WIDTH)
                       && (32'(in_y[5:3]) < ofr_pkg::PANEL_PAGES);
    assign draw_addr = ofr_pkg::ADDR_W'(32'(in_y[5:3]) * ofr_pkg::PANEL_WIDTH + 32'(in_x));
    assign ram_raddr = (in_action == ofr_pkg::ACT_EMIT) ? seq_info.addr : draw_addr;

    ofr_seq u_seq (
        .clk           (clk),
        .rst_n         (rst_n),
        .advance       (accept && (in_action == ofr_pkg::ACT_EMIT)),
        .column_offset (column_offset_reg),
        .page_offset   (page_offset_reg),
        .info          (seq_info)
    );

    ofr_ram #(
        .WIDTH (8),
        .DEPTH (ofr_pkg::STORE_BYTES)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (accept),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        case (color_reg)
            ofr_pkg::COL_OFF: modified = ram_rdata & ~mask_reg;
            ofr_pkg::COL_ON:  modified = ram_rdata | mask_reg;
            ofr_pkg::COL_INV: modified = ram_rdata ^ mask_reg;
            default:          modified = ram_rdata;
        endcase
    end

    assign can_load = !out_valid_reg || m_tready;

    always_comb
    begin
        state_next   = state_reg;
        clr_cnt_next = clr_cnt_reg;
        ram_we       = 1'b0;
        ram_waddr    = addr_reg;
        ram_wdata    = modified;
        load_out     = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (in_action == ofr_pkg::ACT_CLEAR)
                    begin
                        state_next   = ST_CLEAR;
                        clr_cnt_next = '0;
                    end
                    else if (in_action == ofr_pkg::ACT_DRAW || in_action == ofr_pkg::ACT_EMIT)
                    begin
                        state_next = ST_WORK;
                    end
                end
            end
            ST_WORK:
            begin
                if (act_reg == ofr_pkg::ACT_EMIT)
                begin
                    if (can_load)
                    begin
                        load_out   = 1'b1;
                        state_next = ST_IDLE;
                    end
                end
                else
                begin
                    ram_we     = hit_reg;
                    state_next = ST_IDLE;
                end
            end
            ST_CLEAR:
            begin
                ram_we       = 1'b1;
                ram_waddr    = clr_cnt_reg;
                ram_wdata    = 8'h00;
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == ofr_pkg::ADDR_W'(ofr_pkg::STORE_BYTES - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_CLEAR;
            clr_cnt_reg       <= '0;
            out_valid_reg     <= 1'b0;
            column_offset_reg <= 8'd2;
            page_offset_reg   <= 3'd0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    ofr_pkg::REG_COLUMN_OFFSET: column_offset_reg <= cfg_data;
                    ofr_pkg::REG_PAGE_OFFSET:   page_offset_reg   <= cfg_data[2:0];
                    default:                    ;
                endcase
            end
        end
    end

    // item and output payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            act_reg   <= in_action;
            addr_reg  <= draw_addr;
            mask_reg  <= 8'(1) << in_y[2:0];
            color_reg <= in_color;
            hit_reg   <= in_hit;
            info_reg  <= seq_info;
        end
        if (load_out)
        begin
            out_byte_reg <= info_reg.is_cmd ? info_reg.value : ram_rdata;
            out_cmd_reg  <= info_reg.is_cmd;
            out_end_reg  <= info_reg.frame_end;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_byte_reg;
    assign m_tuser  = out_cmd_reg;
    assign m_tlast  = out_end_reg;

endmodule

FILE: src/ofr_checker.sv
`include "oled_framebuffer_refresh_defines.svh"

module ofr_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       s_tvalid,
    input logic       s_tready,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic [0:0] m_tuser,
    input logic       m_tlast
);

    `OFR_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid)

    `OFR_ASSERT_NOW(a_end_on_data, m_tvalid && m_tlast, m_tuser == 1'b0)

    `OFR_ASSERT_NEXT(a_data_hold, m_tvalid && !m_tready, $stable(m_tdata))

    `OFR_ASSERT_NOW(a_out_from_item, $rose(m_tvalid), $past(s_tvalid && s_tready, 2))

endmodule

bind oled_framebuffer_refresh ofr_checker u_ofr_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
